// ----- src/smf_pkg.sv -----
package smf_pkg;

  localparam int MAX_WINDOW = 15;

  localparam int SAMPLE_W = 12;
  localparam int WIN_W    = 4;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = $clog2(MAX_WINDOW);
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SIZE = 2'd1,
    STATUS_SHORT    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Control that every cell of the chain sees in common.
  typedef struct packed {
    logic             load;
    logic             scan;
    logic [IDX_W-1:0] k;
    logic [WIN_W-1:0] n;
  } cell_ctrl_t;

endpackage

// ----- src/smf_cell.sv -----
module smf_cell
  import smf_pkg::*;
(
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [IDX_W-1:0]    idx,
  input  logic [SAMPLE_W-1:0] value_in,
  input  logic [SAMPLE_W-1:0] circ_in,
  input  logic [SAMPLE_W-1:0] bcast,
  output logic [SAMPLE_W-1:0] value,
  output logic [SAMPLE_W-1:0] circ,
  output logic                hit
);

  logic [IDX_W-1:0] rank;
  logic             active;
  logic             below;

  assign active = CNT_W'(idx) < CNT_W'(ctrl.n);

  // Ties are broken by window position so that every rank is distinct.
  assign below = (bcast < value) || ((bcast == value) && (ctrl.k < idx));

  assign hit = active && (rank == IDX_W'(ctrl.n >> 1));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= value_in;
      circ  <= value_in;
    end else if (ctrl.scan) begin
      circ <= circ_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rank <= '0;
    end else if (ctrl.scan && active && below) begin
      rank <= rank + 1'b1;
    end
  end

endmodule

// ----- src/sliding_median_filter_unit.sv -----
// Sliding-window median filter for 12-bit samples. Each accepted item shifts
// its sample into a row of cells that holds the newest samples; when the
// window of window_size samples is full, the copy of the window circulates
// through the row once, one sample a cycle, while every cell counts how many
// window samples rank below its own, and the cell whose rank is the middle
// one gives the median. An item that yields a median passes through the
// scan and then the emit state; an item that yields only a status result
// goes straight to emit, and one that yields nothing leaves the unit idle.
// The result register lets the next item enter while a result still waits.
// Items carry the sample in s_tdata and the end of a record in s_tlast;
// results carry median and status in m_tdata and the end of a record in
// m_tlast. Status 1 flags an even window size or one below three at the end
// of a record, status 2 a record that ended before the window filled.
module sliding_median_filter_unit
  import smf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] sample, [15:12] zero
  input  logic                  s_tlast,   // last_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] median, [13:12] status,
                                           // [15:14] zero
  output logic                  m_tlast,   // last_result
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WIN_W-1:0]      cfg_data   // window_size
);

  state_t               state;
  state_t               state_next;
  logic [WIN_W-1:0]     window_size;
  logic [WIN_W-1:0]     n_reg;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     fill_inc;
  logic [IDX_W-1:0]     k;
  status_t              res_status;
  logic                 res_last;
  status_t              code;
  logic                 need_median;
  logic                 need_result;
  logic                 size_ok;
  logic                 accept;
  logic                 scan_en;
  logic                 scan_done;
  logic                 emit_en;
  cell_ctrl_t           ctrl;
  logic [SAMPLE_W-1:0]  sample;
  logic [SAMPLE_W-1:0]  median;
  logic [SAMPLE_W-1:0]  value [MAX_WINDOW];
  logic [SAMPLE_W-1:0]  circ  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] hit;

  assign sample    = s_tdata[SAMPLE_W-1:0];
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_size <= cfg_data;
    end
  end

  assign fill_inc = (fill == CNT_W'(MAX_WINDOW)) ? fill : fill + 1'b1;
  assign size_ok  = window_size[0] && (window_size > WIN_W'(1)) &&
                    (32'(window_size) <= MAX_WINDOW);

  always_comb begin
    need_median = 1'b0;
    need_result = 1'b0;
    code        = STATUS_OK;
    if (!size_ok) begin
      code        = STATUS_BAD_SIZE;
      need_result = s_tlast;
    end else if (32'(fill_inc) >= 32'(window_size)) begin
      need_median = 1'b1;
    end else begin
      code        = STATUS_SHORT;
      need_result = s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= s_tlast ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_reg      <= window_size;
      res_status <= code;
      res_last   <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (accept) begin
      k <= '0;
    end else if (scan_en) begin
      k <= k + 1'b1;
    end
  end

  assign scan_done = (k == IDX_W'(n_reg - 1'b1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && need_median) begin
          state_next = ST_SCAN;
        end else if (accept && need_result) begin
          state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    scan_en  = 1'b0;
    emit_en  = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SCAN: scan_en  = 1'b1;
      ST_EMIT: emit_en  = !m_tvalid || m_tready;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ctrl.load = accept;
  assign ctrl.scan = scan_en;
  assign ctrl.k    = k;
  assign ctrl.n    = n_reg;

  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic [SAMPLE_W-1:0] value_in;
      logic [SAMPLE_W-1:0] circ_in;
      if (i == 0) begin : g_head
        assign value_in = sample;
      end else begin : g_body
        assign value_in = value[i-1];
      end
      if (i == MAX_WINDOW - 1) begin : g_tail
        assign circ_in = '0;
      end else begin : g_link
        assign circ_in = circ[i+1];
      end
      smf_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .idx      (IDX_W'(i)),
        .value_in (value_in),
        .circ_in  (circ_in),
        .bcast    (circ[0]),
        .value    (value[i]),
        .circ     (circ[i]),
        .hit      (hit[i])
      );
    end
  endgenerate

  // Exactly one active cell holds the middle rank once the scan is over.
  always_comb begin
    median = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (hit[j]) begin
        median = median | value[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      m_tdata <= {(OUT_DATA_W - SAMPLE_W - STATUS_W)'(0), res_status,
                  (res_status == STATUS_OK) ? median : SAMPLE_W'(0)};
      m_tlast <= res_last;
    end
  end

endmodule

// ----- src/smf_checker.sv -----
module smf_checker
  import smf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // A stalled item must hold its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:12] == STATUS_OK) ||
                 (m_tdata[13:12] == STATUS_BAD_SIZE) ||
                 (m_tdata[13:12] == STATUS_SHORT))
    else $error("unknown status code");

  // Error results carry no median and always close a record.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[13:12] != STATUS_OK) |-> m_tdata[11:0] == '0)
    else $error("error result with nonzero median");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[13:12] != STATUS_OK) |-> m_tlast)
    else $error("error result not at end of record");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:14] == '0)
    else $error("padding bits set");

endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- verif/tb_sliding_median_filter_unit.sv -----
typedef struct {
  logic [smf_pkg::SAMPLE_W-1:0] median;
  logic [smf_pkg::STATUS_W-1:0] status;
  logic                         last_result;
} median_result_t;

class median_scoreboard;
  logic [smf_pkg::SAMPLE_W-1:0] history [smf_pkg::MAX_WINDOW];
  int unsigned                  fill_count;
  logic [smf_pkg::WIN_W-1:0]    window_len;
  median_result_t               pending_results [$];
  int                           errors;

  function new();
    foreach (history[i]) history[i] = '0;
    fill_count = 0;
    window_len = smf_pkg::WINDOW_RESET;
    errors     = 0;
  endfunction

  function void set_window(logic [smf_pkg::WIN_W-1:0] n);
    window_len = n;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function logic [smf_pkg::SAMPLE_W-1:0] window_median(int unsigned n);
    logic [smf_pkg::SAMPLE_W-1:0] sorted [smf_pkg::MAX_WINDOW];
    logic [smf_pkg::SAMPLE_W-1:0] v;
    int                           j;
    for (int i = 0; i < n; i++) begin
      v = history[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[n/2];
  endfunction

  // Works out the result, if any, caused by one accepted item.
  function void note_input(logic [smf_pkg::SAMPLE_W-1:0] smp, logic last);
    median_result_t r;
    int unsigned    n;
    bit             len_ok;
    n = window_len;
    for (int i = smf_pkg::MAX_WINDOW - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = smp;
    if (fill_count < smf_pkg::MAX_WINDOW) fill_count++;
    len_ok = n[0] && n > 1 && n <= smf_pkg::MAX_WINDOW;
    if (!len_ok) begin
      if (last) begin
        r.median      = '0;
        r.status      = smf_pkg::STATUS_BAD_SIZE;
        r.last_result = 1'b1;
        pending_results.push_back(r);
      end
    end else if (fill_count >= n) begin
      r.median      = window_median(n);
      r.status      = smf_pkg::STATUS_OK;
      r.last_result = last;
      pending_results.push_back(r);
    end else if (last) begin
      r.median      = '0;
      r.status      = smf_pkg::STATUS_SHORT;
      r.last_result = 1'b1;
      pending_results.push_back(r);
    end
    if (last) fill_count = 0;
  endfunction

  function void check_result(logic [smf_pkg::SAMPLE_W-1:0] med,
                             logic [smf_pkg::STATUS_W-1:0] st, logic lst);
    median_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result: median %0d status %0d last_result %0d", med, st, lst);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (med !== e.median) begin
      $error("median: expected %0d, actual %0d", e.median, med);
      errors++;
    end
    if (st !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, st);
      errors++;
    end
    if (lst !== e.last_result) begin
      $error("last_result: expected %0d, actual %0d", e.last_result, lst);
      errors++;
    end
  endfunction
endclass

module tb_sliding_median_filter_unit;
  import smf_pkg::*;

  localparam int SETTLE_CYCLES = MAX_WINDOW + 5;
  localparam int STALL_LIMIT   = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [WIN_W-1:0]      cfg_data = '0;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          stall_count = 0;
  int unsigned record_left = 0;
  int unsigned sample_mode = 0;

  median_scoreboard sb = new();

  sliding_median_filter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tdata[SAMPLE_W-1:0], s_tlast);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[SAMPLE_W-1:0], m_tdata[SAMPLE_W +: STATUS_W], m_tlast);
  end

  // Ends a hung run: counts cycles in which no handshake completes.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic last);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-SAMPLE_W){1'b0}}, smp};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds the sender off until every expected result is out and the
  // pipeline has had time to finish items that cause no result.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] n);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    sb.set_window(n);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case (sample_mode)
      0: return SAMPLE_W'($urandom_range(0, 4095));
      1: return SAMPLE_W'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
      default: return SAMPLE_W'($urandom_range(2000, 2100));
    endcase
  endfunction

  task automatic run_random(input int tx_pct, input int rx_pct, input int count);
    int          sent;
    int          phase_end;
    int unsigned n;
    int unsigned span;
    int unsigned r;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 9);
      n = (r < 7) ? 2 * $urandom_range(1, 7) + 1 : $urandom_range(0, 15);
      write_window(WIN_W'(n));
      span = (n < 3) ? 3 : n;
      phase_end = sent + $urandom_range(80, 180);
      // Records run on across window changes, so some changes land mid-record.
      while (sent < phase_end && sent < count) begin
        if (record_left == 0) begin
          r = $urandom_range(0, 9);
          if (r < 2) record_left = $urandom_range(1, span);
          else if (r < 8) record_left = $urandom_range(span, 3 * span + 4);
          else record_left = $urandom_range(20, 60);
          r = $urandom_range(0, 9);
          sample_mode = (r < 6) ? 0 : r - 6;
        end
        send_item(pick_sample(), record_left == 1);
        record_left--;
        sent++;
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window of three from reset: extremes, a one-item record, a two-item record.
    send_item(12'h000, 1'b0);
    send_item(12'hFFF, 1'b0);
    send_item(12'hAAA, 1'b0);
    send_item(12'h555, 1'b1);
    send_item(12'h123, 1'b1);
    send_item(12'hFFF, 1'b0);
    send_item(12'h000, 1'b1);

    // Largest window, filled exactly by one record.
    write_window(WIN_W'(MAX_WINDOW));
    for (int i = 0; i < MAX_WINDOW; i++) begin
      send_item((i == 7) ? 12'hFFF : SAMPLE_W'((i * 731) % 4096), i == MAX_WINDOW - 1);
    end

    // Invalid sizes: even, one and zero.
    write_window(WIN_W'(4));
    send_item(12'h001, 1'b0);
    send_item(12'h002, 1'b1);
    write_window(WIN_W'(1));
    send_item(12'h005, 1'b1);
    write_window(WIN_W'(0));
    send_item(12'h007, 1'b1);

    run_random(14, 77, 700);
    run_random(77, 14, 700);
    run_random(0, 0, 700);

    drain_results();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
